>>> design/wake_word_detection_window_unit_assert.svh
// Assertion macros shared by the wake word detection window RTL.
`ifndef WAKE_WORD_DETECTION_WINDOW_UNIT_ASSERT_SVH
`define WAKE_WORD_DETECTION_WINDOW_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define WWDW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define WWDW_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/wwdw_pkg.sv
`default_nettype none

package wwdw_pkg;

  // Score byte width
  localparam int unsigned ProbW = 8;

  // Request operation codes
  localparam logic OP_SLICE  = 1'b0;
  localparam logic OP_DETECT = 1'b1;

  // Configuration register reset values
  localparam logic [7:0] CUTOFF_RST   = 8'd128;
  localparam logic [5:0] WINDOW_RST   = 6'd10;
  localparam logic [3:0] STRIDE_RST   = 4'd3;
  localparam logic [7:0] COOLDOWN_RST = 8'd100;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CUTOFF   = 2'd0,
    CFG_WINDOW   = 2'd1,
    CFG_STRIDE   = 2'd2,
    CFG_COOLDOWN = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    cfg_reg_e   index;
    logic [7:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic             operation;
    logic [ProbW-1:0] probability;
  } req_t;

  typedef struct packed {
    logic             probability_taken;
    logic             evaluated;
    logic             detected;
    logic [ProbW-1:0] avg_score;
    logic [ProbW-1:0] peak_score;
    logic             unprocessed_pending;
  } rsp_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

>>> design/wwdw_chan_if.sv
`default_nettype none

interface wwdw_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/wwdw_div.sv
`default_nettype none

// Restoring divider: one quotient bit per cycle, quotient known to fit a byte.
module wwdw_div #(
  parameter int unsigned DendW = 14,
  parameter int unsigned DsorW = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DendW-1:0]        dividend_i,
  input  logic [DsorW-1:0]        divisor_i,
  output wwdw_pkg::div_status_t   status_o,
  output logic [wwdw_pkg::ProbW-1:0] quot_o
);
  import wwdw_pkg::*;

  localparam int unsigned TrialW = DendW + ProbW;
  localparam int unsigned BitW   = $clog2(ProbW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [BitW-1:0]  bit_q, bit_d;
  logic [DendW-1:0] rem_q, rem_d;
  logic [DsorW-1:0] dsor_q, dsor_d;
  logic [ProbW-1:0] quot_q, quot_d;
  logic [TrialW-1:0] trial;
  logic             fits;

  // Shifted divisor against the running remainder
  assign trial = TrialW'(dsor_q) << bit_q;
  assign fits  = TrialW'(rem_q) >= trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    bit_d  = bit_q;
    rem_d  = rem_q;
    dsor_d = dsor_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      bit_d  = BitW'(ProbW - 1);
      rem_d  = dividend_i;
      dsor_d = divisor_i;
      quot_d = '0;
    end else if (busy_q) begin
      // Subtract when the shifted divisor fits, shift in the quotient bit
      if (fits) begin
        rem_d = rem_q - trial[DendW-1:0];
      end
      quot_d = {quot_q[ProbW-2:0], fits};
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        bit_d = bit_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsor_q <= dsor_d;
    quot_q <= quot_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule

`default_nettype wire

>>> design/wake_word_detection_window_unit.sv
// Wake word detection window unit.
// req_i carries one request per item: operation 0 is a feature slice with its
// score byte, operation 1 asks for a detection decision. rsp_o returns exactly
// one response per request. cfg_i writes the cutoff, window size, stride and
// cool-down registers; it is always ready and should be used only while idle.
// A slice passes through S_MOD, which repeats once for each stride reduction
// needed after the stride register was lowered, then S_RD, S_CMP and S_DONE.
// A detect request with cool-down running goes straight to S_DONE. An evaluating detect
// walks the score store one entry per cycle through its single read port, then
// runs the restoring divider before S_DONE.
// One request is in flight at a time; req_i.ready is high only when idle, so
// the next request can be accepted in the cycle after a response is loaded.
// The response sits in an output register; a stalled receiver holds it there
// while the next request is accepted, and that request's response waits for
// the register to free up.
// Reset loads the register defaults, zeroes the stride and ring indexes, loads
// the cool-down count with 100 and marks every stored score as zero through
// per-entry valid flags, so no clearing pass is needed.
`default_nettype none

`include "wake_word_detection_window_unit_assert.svh"

module wake_word_detection_window_unit #(
  parameter int unsigned WINDOW_DEPTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wwdw_chan_if.sink    req_i,
  wwdw_chan_if.source  rsp_o,
  wwdw_chan_if.sink    cfg_i
);
  import wwdw_pkg::*;

  localparam int unsigned IdxW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned WsW  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SumW = ProbW + WsW;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MOD    = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_CMP    = 4'd3;
  localparam logic [3:0] S_SWEEP  = 4'd4;
  localparam logic [3:0] S_THRESH = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_DONE   = 4'd7;

  // Configuration registers
  logic [7:0] cutoff_q;
  logic [5:0] window_q;
  logic [3:0] stride_q;
  logic [7:0] cooldown_slices_q;

  // Control state
  logic [3:0]              state_q, state_d;
  logic [3:0]              step_q, step_d;
  logic [IdxW-1:0]         write_index_q, write_index_d;
  logic [7:0]              cooldown_q, cooldown_d;
  logic                    pending_q, pending_d;
  logic [WINDOW_DEPTH-1:0] valid_q, valid_d;
  logic                    out_valid_q, out_valid_d;
  logic                    acc_pend_q, acc_pend_d;

  // Working registers
  logic [ProbW-1:0] prob_q, prob_d;
  logic [WsW-1:0]   cnt_q, cnt_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [ProbW-1:0] max_q, max_d;
  logic             res_taken_q, res_taken_d;
  logic             res_eval_q, res_eval_d;
  logic             res_det_q, res_det_d;
  logic [ProbW-1:0] res_avg_q, res_avg_d;
  rsp_t             out_q, out_d;

  // Score store
  logic [ProbW-1:0] score_mem_q [WINDOW_DEPTH];
  logic [ProbW-1:0] rdata_q;
  logic             rvalid_q;
  logic             rd_en, wr_en;
  logic [IdxW-1:0]  rd_addr;
  logic [ProbW-1:0] rd_byte;

  // Effective settings and shared arithmetic
  logic [6:0]       win_ext;
  logic [WsW-1:0]   ws;
  logic [3:0]       stride_eff;
  logic [3:0]       step_inc;
  logic [WsW:0]     idx_inc;
  logic [IdxW-1:0]  idx_next;
  logic [SumW-1:0]  thresh;

  logic             div_start;
  div_status_t      div_status;
  logic [ProbW-1:0] div_quot;

  // Clamp window size to 1..WINDOW_DEPTH, stride to at least 1
  assign win_ext    = 7'(window_q);
  assign ws         = (window_q == '0) ? WsW'(1) :
                      (win_ext > 7'(WINDOW_DEPTH)) ? WsW'(WINDOW_DEPTH) : WsW'(window_q);
  assign stride_eff = (stride_q == '0) ? 4'd1 : stride_q;
  assign step_inc   = step_q + 4'd1;

  // Ring index advance with wrap at the window size
  assign idx_inc  = (WsW + 1)'(write_index_q) + (WsW + 1)'(1);
  assign idx_next = (idx_inc >= (WsW + 1)'(ws)) ? '0 : IdxW'(idx_inc);

  assign thresh  = SumW'(cutoff_q) * SumW'(ws);
  assign rd_byte = rvalid_q ? rdata_q : '0;

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  wwdw_div #(
    .DendW (SumW),
    .DsorW (WsW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (ws),
    .status_o   (div_status),
    .quot_o     (div_quot)
  );

  // Sequencer
  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    write_index_d = write_index_q;
    cooldown_d    = cooldown_q;
    pending_d     = pending_q;
    valid_d       = valid_q;
    acc_pend_d    = acc_pend_q;
    prob_d        = prob_q;
    cnt_d         = cnt_q;
    sum_d         = sum_q;
    max_d         = max_q;
    res_taken_d   = res_taken_q;
    res_eval_d    = res_eval_q;
    res_det_d     = res_det_q;
    res_avg_d     = res_avg_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    rd_en         = 1'b0;
    rd_addr       = write_index_q;
    wr_en         = 1'b0;
    div_start     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          prob_d      = req_i.data.probability;
          res_taken_d = 1'b0;
          res_eval_d  = 1'b0;
          res_det_d   = 1'b0;
          res_avg_d   = '0;
          max_d       = '0;
          if (req_i.data.operation == OP_SLICE) begin
            state_d = S_MOD;
          end else if (cooldown_q != '0) begin
            state_d = S_DONE;
          end else begin
            cnt_d      = '0;
            sum_d      = '0;
            acc_pend_d = 1'b0;
            state_d    = S_SWEEP;
          end
        end
      end
      S_MOD: begin
        // Reduce the stride step below the stride, then advance it
        if (step_q >= stride_eff) begin
          step_d = step_q - stride_eff;
        end else begin
          step_d = step_inc;
          if (step_inc >= stride_eff) begin
            wr_en              = 1'b1;
            write_index_d      = idx_next;
            valid_d[idx_next]  = 1'b1;
            pending_d          = 1'b1;
            res_taken_d        = 1'b1;
          end
          state_d = S_RD;
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        rd_addr = write_index_q;
        state_d = S_CMP;
      end
      S_CMP: begin
        // Count down the cool-down while the latest score is below cutoff
        if ((rd_byte < cutoff_q) && (cooldown_q != '0)) begin
          cooldown_d = cooldown_q - 8'd1;
        end
        state_d = S_DONE;
      end
      S_SWEEP: begin
        // Accumulate the entry read last cycle, issue the next read
        if (acc_pend_q) begin
          sum_d = sum_q + SumW'(rd_byte);
          if (rd_byte > max_q) begin
            max_d = rd_byte;
          end
        end
        if (cnt_q < ws) begin
          rd_en      = 1'b1;
          rd_addr    = cnt_q[IdxW-1:0];
          cnt_d      = cnt_q + WsW'(1);
          acc_pend_d = 1'b1;
        end else begin
          acc_pend_d = 1'b0;
          if (!acc_pend_q) begin
            state_d = S_THRESH;
          end
        end
      end
      S_THRESH: begin
        res_det_d  = (sum_q > thresh);
        res_eval_d = 1'b1;
        div_start  = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        if (div_status.done) begin
          res_avg_d = div_quot;
          pending_d = 1'b0;
          // On detection drop the window and restart the cool-down
          if (res_det_q) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
              if (i < int'(ws)) begin
                valid_d[i] = 1'b0;
              end
            end
            cooldown_d = cooldown_slices_q;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d               = 1'b1;
          out_d.probability_taken   = res_taken_q;
          out_d.evaluated           = res_eval_q;
          out_d.detected            = res_det_q;
          out_d.avg_score           = res_avg_q;
          out_d.peak_score          = max_q;
          out_d.unprocessed_pending = pending_q;
          state_d                   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q          <= CUTOFF_RST;
      window_q          <= WINDOW_RST;
      stride_q          <= STRIDE_RST;
      cooldown_slices_q <= COOLDOWN_RST;
      state_q           <= S_IDLE;
      step_q            <= '0;
      write_index_q     <= '0;
      cooldown_q        <= COOLDOWN_RST;
      pending_q         <= 1'b0;
      valid_q           <= '0;
      out_valid_q       <= 1'b0;
      acc_pend_q        <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          CFG_CUTOFF:   cutoff_q          <= cfg_i.data.wdata;
          CFG_WINDOW:   window_q          <= cfg_i.data.wdata[5:0];
          CFG_STRIDE:   stride_q          <= cfg_i.data.wdata[3:0];
          CFG_COOLDOWN: cooldown_slices_q <= cfg_i.data.wdata;
          default: ;
        endcase
      end
      state_q       <= state_d;
      step_q        <= step_d;
      write_index_q <= write_index_d;
      cooldown_q    <= cooldown_d;
      pending_q     <= pending_d;
      valid_q       <= valid_d;
      out_valid_q   <= out_valid_d;
      acc_pend_q    <= acc_pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prob_q      <= prob_d;
    cnt_q       <= cnt_d;
    sum_q       <= sum_d;
    max_q       <= max_d;
    res_taken_q <= res_taken_d;
    res_eval_q  <= res_eval_d;
    res_det_q   <= res_det_d;
    res_avg_q   <= res_avg_d;
    out_q       <= out_d;
  end

  // Score store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      score_mem_q[idx_next] <= prob_q;
    end
    if (rd_en) begin
      rdata_q  <= score_mem_q[rd_addr];
      rvalid_q <= valid_q[rd_addr];
    end
  end

  `WWDW_ASSERT(a_sweep_cooled, (state_q == S_SWEEP) |-> (cooldown_q == '0), "sweep with cool-down running")
  `WWDW_ASSERT(a_det_eval, (rsp_o.valid && rsp_o.data.detected) |-> rsp_o.data.evaluated, "detected without evaluation")
  `WWDW_ASSERT(a_max_avg, (rsp_o.valid && rsp_o.data.evaluated) |-> (rsp_o.data.peak_score >= rsp_o.data.avg_score), "average above maximum")
  `WWDW_ASSERT(a_taken_pend, (rsp_o.valid && rsp_o.data.probability_taken) |-> rsp_o.data.unprocessed_pending, "stored score not marked pending")
  `WWDW_ASSERT_NEXT(a_accept_busy, (req_i.valid && req_i.ready), (state_q != S_IDLE), "accepted request left sequencer idle")

endmodule

`default_nettype wire

>>> test/tb_wake_word_detection_window_unit.sv
module tb_wake_word_detection_window_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import wwdw_pkg::*;

  localparam int unsigned Depth       = 32;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned SettleDelay = 4;
  localparam int unsigned DrainDelay  = 60;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned PhaseItems  = 80;

  logic clk_i;
  logic rst_ni;

  wwdw_chan_if #(.payload_t(req_t)) req_if ();
  wwdw_chan_if #(.payload_t(rsp_t)) rsp_if ();
  wwdw_chan_if #(.payload_t(cfg_t)) cfg_if ();

  wake_word_detection_window_unit #(
    .WINDOW_DEPTH(Depth)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Register shadow copies
  logic [7:0] cutoff_q;
  logic [5:0] window_q;
  logic [3:0] stride_q;
  logic [7:0] cooldown_q;

  // Detector state as the testbench sees it
  logic [7:0]  score_ring [Depth];
  int unsigned ring_pos;
  int unsigned slice_count;
  int unsigned cooldown_left;
  bit          pending_q;

  rsp_t expected_rsp_q [$];

  // Pacing knobs shared by the driver and the response side
  int unsigned send_idle_pct;
  int unsigned rsp_stall_pct;
  int unsigned hold_request;

  int unsigned sent_count;
  int unsigned cfg_count;
  int unsigned eval_count;
  int unsigned detect_count;
  int unsigned error_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reset_detector_state();
    cutoff_q      = CUTOFF_RST;
    window_q      = WINDOW_RST;
    stride_q      = STRIDE_RST;
    cooldown_q    = COOLDOWN_RST;
    foreach (score_ring[i]) score_ring[i] = '0;
    ring_pos      = 0;
    slice_count   = 0;
    cooldown_left = COOLDOWN_RST;
    pending_q     = 1'b0;
  endfunction

  // Clamp the window register to 1..Depth
  function automatic int unsigned active_window();
    if (window_q == 0) return 1;
    if (window_q > Depth) return Depth;
    return window_q;
  endfunction

  // Advance the detector by one request and build the response it owes
  function automatic rsp_t predict_response(req_t item);
    rsp_t        r;
    int unsigned span;
    int unsigned stride;
    int unsigned total;
    int unsigned top;
    int unsigned i;
    r    = '0;
    span = active_window();
    if (item.operation == OP_SLICE) begin
      stride      = (stride_q == 0) ? 1 : stride_q;
      slice_count = (slice_count % stride) + 1;
      if (slice_count >= stride) begin
        ring_pos++;
        if (ring_pos >= span) ring_pos = 0;
        score_ring[ring_pos] = item.probability;
        pending_q           = 1'b1;
        r.probability_taken = 1'b1;
      end
      if (score_ring[ring_pos] < cutoff_q && cooldown_left > 0) cooldown_left--;
    end else if (cooldown_left == 0) begin
      total = 0;
      top   = 0;
      for (i = 0; i < span; i++) begin
        if (score_ring[i] > top) top = score_ring[i];
        total += score_ring[i];
      end
      r.evaluated  = 1'b1;
      r.detected   = (total > cutoff_q * span);
      r.avg_score  = 8'(total / span);
      r.peak_score = 8'(top);
      pending_q    = 1'b0;
      if (r.detected) begin
        for (i = 0; i < span; i++) score_ring[i] = '0;
        cooldown_left = cooldown_q;
      end
    end
    r.unprocessed_pending = pending_q;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  task automatic check_response(input rsp_t got);
    rsp_t want;
    if (expected_rsp_q.size() == 0) begin
      $display("%0t: response with nothing expected: expected none, actual %p", $time, got);
      error_count++;
    end else begin
      want = expected_rsp_q.pop_front();
      compare_field("probability_taken", 8'(want.probability_taken),
                    8'(got.probability_taken));
      compare_field("evaluated", 8'(want.evaluated), 8'(got.evaluated));
      compare_field("detected", 8'(want.detected), 8'(got.detected));
      compare_field("avg_score", want.avg_score, got.avg_score);
      compare_field("peak_score", want.peak_score, got.peak_score);
      compare_field("unprocessed_pending", 8'(want.unprocessed_pending),
                    8'(got.unprocessed_pending));
      if (want.evaluated) eval_count++;
      if (want.detected) detect_count++;
    end
  endtask

  // Offer one request; valid stays high afterwards so the next one can follow at once
  task automatic send_request(input logic op, input logic [7:0] prob);
    req_t item;
    item.operation   = op;
    item.probability = prob;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    do @(posedge clk_i); while (!req_if.ready);
    expected_rsp_q.push_back(predict_response(item));
    sent_count++;
  endtask

  task automatic wait_for_idle();
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SettleDelay) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e index, input logic [7:0] value);
    cfg_t w;
    w.index = index;
    w.wdata = value;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (index)
      CFG_CUTOFF:   cutoff_q   = value;
      CFG_WINDOW:   window_q   = value[5:0];
      CFG_STRIDE:   stride_q   = value[3:0];
      CFG_COOLDOWN: cooldown_q = value;
      default: ;
    endcase
    cfg_count++;
  endtask

  // Drop the request line, drain the block, then rewrite all four registers
  task automatic configure(input logic [7:0] cutoff, input logic [7:0] window,
                           input logic [7:0] stride, input logic [7:0] cooldown);
    req_if.valid <= 1'b0;
    wait_for_idle();
    write_register(CFG_CUTOFF, cutoff);
    write_register(CFG_WINDOW, window);
    write_register(CFG_STRIDE, stride);
    write_register(CFG_COOLDOWN, cooldown);
    cfg_if.valid <= 1'b0;
  endtask

  // Detect under the reset cool-down, then a first stride landing at index 1
  task automatic test_reset_state();
    send_request(OP_DETECT, 8'hFF);
    send_request(OP_SLICE, 8'h00);
    send_request(OP_SLICE, 8'hFF);
    send_request(OP_SLICE, 8'hFF);
    send_request(OP_DETECT, 8'h00);
  endtask

  // Run the reset cool-down out with below-cutoff scores
  task automatic test_cooldown_release();
    configure(8'hFF, 8'd4, 8'd1, 8'd0);
    repeat (100) send_request(OP_SLICE, 8'($urandom_range(254)));
    send_request(OP_DETECT, 8'h00);
  endtask

  // Sum equal to and just above cutoff times window
  task automatic test_threshold_edges();
    configure(8'd0, 8'd1, 8'd1, 8'd0);
    send_request(OP_SLICE, 8'd0);
    send_request(OP_DETECT, 8'd0);
    send_request(OP_SLICE, 8'd1);
    send_request(OP_DETECT, 8'd0);
    configure(8'hFF, 8'd2, 8'd1, 8'd0);
    send_request(OP_SLICE, 8'hFF);
    send_request(OP_SLICE, 8'hFF);
    send_request(OP_DETECT, 8'd0);
    configure(8'hFE, 8'd2, 8'd1, 8'd0);
    send_request(OP_DETECT, 8'd0);
    send_request(OP_DETECT, 8'd0);
  endtask

  // Window of zero, above the store depth, and stride of zero
  task automatic test_window_limits();
    configure(8'd10, 8'd0, 8'd1, 8'd0);
    send_request(OP_SLICE, 8'd200);
    send_request(OP_DETECT, 8'd0);
    configure(8'd10, 8'hFF, 8'd0, 8'd0);
    send_request(OP_SLICE, 8'hFF);
    send_request(OP_SLICE, 8'h80);
    send_request(OP_SLICE, 8'hFF);
    send_request(OP_DETECT, 8'd0);
    configure(8'd200, 8'd33, 8'd1, 8'd0);
    send_request(OP_SLICE, 8'd7);
    send_request(OP_DETECT, 8'd0);
  endtask

  // Longest stride, then lower the stride with a partial count in flight
  task automatic test_stride_change();
    configure(8'd128, 8'd4, 8'd15, 8'd0);
    repeat (15) send_request(OP_SLICE, 8'($urandom_range(255)));
    repeat (5) send_request(OP_SLICE, 8'($urandom_range(255)));
    configure(8'd128, 8'd4, 8'd3, 8'd0);
    send_request(OP_SLICE, 8'hC3);
    send_request(OP_DETECT, 8'd0);
  endtask

  // Hold the response side off so the request side backs up
  task automatic test_output_backpressure();
    configure(8'd100, 8'd6, 8'd1, 8'd0);
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_request  = LongHold;
    repeat (12) send_request(($urandom_range(99) < 30), 8'($urandom_range(255)));
  endtask

  // Random register settings, biased toward small windows and strides
  task automatic configure_random();
    logic [7:0] cutoff;
    logic [7:0] window;
    logic [7:0] stride;
    logic [7:0] cooldown;
    case ($urandom_range(5))
      0:       cutoff = 8'd0;
      1:       cutoff = 8'hFF;
      default: cutoff = 8'($urandom_range(220, 40));
    endcase
    case ($urandom_range(9))
      0:       window = 8'd0;
      1:       window = 8'd32;
      2:       window = 8'($urandom_range(63, 33));
      3:       window = 8'($urandom_range(31, 9));
      default: window = 8'($urandom_range(8, 1));
    endcase
    case ($urandom_range(9))
      0:       stride = 8'd0;
      1:       stride = 8'd15;
      2:       stride = 8'($urandom_range(14, 4));
      default: stride = 8'($urandom_range(3, 1));
    endcase
    cooldown = ($urandom_range(49) == 0) ? 8'hFF : 8'($urandom_range(4));
    // Stray upper bits must be dropped by the narrow registers
    window[7:6] = 2'($urandom_range(3));
    stride[7:4] = 4'($urandom_range(15));
    configure(cutoff, window, stride, cooldown);
  endtask

  // Bursts of slices and detects with scores above, below or around the cutoff
  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned left;
    int unsigned burst;
    int unsigned bias;
    int unsigned detect_pct;
    logic [7:0]  prob;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    left = PhaseItems;
    while (left != 0) begin
      configure_random();
      burst      = $urandom_range(40, 12);
      burst      = (burst > left) ? left : burst;
      bias       = $urandom_range(3);
      detect_pct = (bias == 3) ? 70 : 20;
      repeat (burst) begin
        case (bias)
          1:       prob = 8'($urandom_range(255, cutoff_q));
          2:       prob = 8'($urandom_range(cutoff_q, 0));
          default: prob = 8'($urandom_range(255));
        endcase
        send_request(($urandom_range(99) < detect_pct), prob);
      end
      left -= burst;
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0);
    run_random_phase(83, 0);
    run_random_phase(0, 83);
    run_random_phase(35, 35);
    send_idle_pct = 0;
    rsp_stall_pct = 0;
  endtask

  // Detection with the largest cool-down, then detects that stay blocked
  task automatic test_long_cooldown();
    configure(8'hFF, 8'd1, 8'd1, 8'hFF);
    repeat (cooldown_left) send_request(OP_SLICE, 8'($urandom_range(254)));
    configure(8'd0, 8'd1, 8'd1, 8'hFF);
    send_request(OP_SLICE, 8'd5);
    send_request(OP_DETECT, 8'd0);
    send_request(OP_DETECT, 8'd0);
    repeat (6) send_request(OP_SLICE, 8'($urandom_range(255)));
    send_request(OP_DETECT, 8'd0);
  endtask

  // Response side: check accepted responses, pace ready
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) check_response(rsp_if.data);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Watchdog: stop when no channel moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
    $display("FAIL wake_word_detection_window_unit");
    $finish;
  end

  initial begin
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_request  = 0;
    sent_count    = 0;
    cfg_count     = 0;
    eval_count    = 0;
    detect_count  = 0;
    error_count   = 0;
    reset_detector_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_cooldown_release();
    test_threshold_edges();
    test_window_limits();
    test_stride_change();
    test_output_backpressure();
    test_random_traffic();
    test_long_cooldown();

    // Drain everything still in flight
    req_if.valid <= 1'b0;
    wait_for_idle();
    repeat (DrainDelay) @(posedge clk_i);

    $display("Covered %0d requests and %0d register writes under four pacing mixes.",
             sent_count, cfg_count);
    $display("Responses held %0d evaluations and %0d detections; %0d mismatches.",
             eval_count, detect_count, error_count);
    if (error_count == 0) begin
      $display("PASS wake_word_detection_window_unit");
    end else begin
      $display("FAIL wake_word_detection_window_unit");
    end
    $finish;
  end

endmodule
